### rtl/pbfa_pkg.sv
// Shared constants and types for the packed bit-field array.
package pbfa_pkg;

    localparam int CAP_BITS   = 32768;                 // store capacity in bits
    localparam int WORD_W     = 64;                    // bits per memory word
    localparam int LANES      = WORD_W / 8;            // bytes per word
    localparam int ROWS       = CAP_BITS / (2 * WORD_W); // rows per bank
    localparam int ROW_AW     = $clog2(ROWS);
    localparam int WORD_AW    = ROW_AW + 1;            // word address, bank in LSB
    localparam int OFF_W      = $clog2(WORD_W);        // bit offset inside a word
    localparam int UNIT_W     = 7;
    localparam int COUNT_W    = 16;
    localparam int INDEX_W    = 15;
    localparam int QUOT_W     = $clog2(CAP_BITS) + 1;  // quotient of CAP_BITS / width
    localparam int NBYTE_W    = $clog2(CAP_BITS / 8) + 1;
    localparam int BASE_W     = INDEX_W + UNIT_W;
    localparam int MAX_UNIT   = 64;

    // configuration register indexes
    localparam logic CFG_UNIT_BITS = 1'b0;
    localparam logic CFG_ELEM_CNT  = 1'b1;

    typedef enum logic [2:0] {
        OP_READ  = 3'd0,
        OP_WRITE = 3'd1,
        OP_CLEAR = 3'd2,
        OP_SET   = 3'd3,
        OP_TEST  = 3'd4,
        OP_FILL0 = 3'd5,
        OP_FILL1 = 3'd6
    } t_op;

endpackage

### rtl/packed_bitfield_array_top.sv
// Top level of the packed bit-field array: control, field extract and merge.
//
//  channel  dir  handshake                      payload
//  -------  ---  -----------------------------  -----------------------------------
//  in       in   i_in_valid / o_in_stall        i_operation, i_index, i_value
//  out      out  o_out_valid / i_out_stall      o_read_value, o_is_nonzero, o_status
//  cfg      in   i_cfg_we (no handshake back)   i_cfg_index, i_cfg_wdata
//
// Element ops read both banks at the accept edge (an element spans at most two
// 64-bit words, always one even and one odd); the next edge merges and writes back.
// Fills start the width divider on accept, then write each 16-byte row touched (up
// to 256 rows) in S_FILL, and finish once past the used length.
// After reset a clearing pass zeroes all 256 rows of the store; o_in_stall is high
// during it. A transaction is accepted while a result still waits on a stalled
// output; its result then parks in a holding register and the input stalls.
module packed_bitfield_array_top
    import pbfa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input transactions
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [2:0]           i_operation,
    input  logic [INDEX_W-1:0]   i_index,
    input  logic [WORD_W-1:0]    i_value,
    // result transactions
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [WORD_W-1:0]    o_read_value,
    output logic                 o_is_nonzero,
    output logic                 o_status,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [COUNT_W-1:0]   i_cfg_wdata
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_MOD   = 6'b000100,
        S_DIV   = 6'b001000,
        S_FILL  = 6'b010000,
        S_HOLD  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [UNIT_W-1:0]  r_unit;
    logic [COUNT_W-1:0] r_count;
    logic [UNIT_W-1:0]  w_eff;

    // transaction in flight
    t_op                r_op;
    logic [WORD_W-1:0]  r_value;
    logic [WORD_AW-1:0] r_word;
    logic [OFF_W-1:0]   r_off;
    logic               r_ok;

    // sweep (clear and fill)
    logic [ROW_AW:0]    r_row;
    logic [NBYTE_W-1:0] r_nbytes;

    // result path
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_rd;
    logic               r_out_nz;
    logic               r_out_st;
    logic [WORD_W-1:0]  r_pend_rd;
    logic               r_pend_nz;
    logic               r_pend_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit  <= UNIT_W'(1);
            r_count <= COUNT_W'(CAP_BITS);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_UNIT_BITS: r_unit  <= i_cfg_wdata[UNIT_W-1:0];
                CFG_ELEM_CNT:  r_count <= i_cfg_wdata;
                default:       r_count <= r_count;
            endcase
        end
    end

    // width 0 acts as 1, anything above the maximum as the maximum
    assign w_eff = (r_unit == '0) ? UNIT_W'(1) :
                   (r_unit > UNIT_W'(MAX_UNIT)) ? UNIT_W'(MAX_UNIT) : r_unit;

    // ---------------- accept stage: address and range check ----------------
    logic               w_accept;
    logic [BASE_W-1:0]  w_base;
    logic               w_ok;
    logic [WORD_AW-1:0] w_word;
    logic [WORD_AW-1:0] w_word_nx;
    logic [WORD_AW-1:0] w_rword_nx;
    logic               w_is_fill;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_base     = BASE_W'(i_index) * BASE_W'(w_eff);
    // index < min(count, capacity/width) without a divide
    assign w_ok       = ((BASE_W+1)'(w_base) + (BASE_W+1)'(w_eff) <= (BASE_W+1)'(CAP_BITS))
                        && ({1'b0, i_index} < r_count);
    assign w_word     = w_base[OFF_W +: WORD_AW];
    assign w_word_nx  = w_word + 1'b1;
    assign w_rword_nx = r_word + 1'b1;
    assign w_is_fill  = (i_operation == OP_FILL0) || (i_operation == OP_FILL1);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= t_op'(i_operation);
            r_value <= i_value;
            r_word  <= w_word;
            r_off   <= w_base[OFF_W-1:0];
            r_ok    <= w_ok;
        end
    end

    // ---------------- width divider for fills ----------------
    logic              w_div_done;
    logic [QUOT_W-1:0] w_quot;
    logic [QUOT_W-1:0] w_cnt_min;
    logic [BASE_W:0]   w_total;

    pbfa_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept && w_is_fill),
        .i_divisor (w_eff),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    assign w_cnt_min = (QUOT_W'(r_count) < w_quot) ? QUOT_W'(r_count) : w_quot;
    assign w_total   = (BASE_W+1)'(w_cnt_min) * (BASE_W+1)'(w_eff);

    // ---------------- memory banks ----------------
    logic [WORD_W-1:0] w_q0, w_q1;
    logic [ROW_AW-1:0] w_addr0, w_addr1;
    logic              w_we;
    logic [LANES-1:0]  w_be0, w_be1;
    logic [WORD_W-1:0] w_wd0, w_wd1;

    // ---------------- field extract and merge ----------------
    logic [WORD_W-1:0]   w_hi, w_lo;
    logic [2*WORD_W-1:0] w_pair, w_shl, w_m128, w_d128, w_new;
    logic [UNIT_W-1:0]   w_rsh;
    logic [WORD_W-1:0]   w_mask_top, w_val_top, w_elem;
    logic                w_elem_op, w_wr_op;

    assign w_hi       = r_word[0] ? w_q1 : w_q0;
    assign w_lo       = r_word[0] ? w_q0 : w_q1;
    assign w_pair     = {w_hi, w_lo};
    assign w_shl      = w_pair << r_off;
    assign w_rsh      = UNIT_W'(MAX_UNIT) - w_eff;
    assign w_mask_top = ~({WORD_W{1'b1}} >> w_eff);
    assign w_elem     = w_shl[2*WORD_W-1:WORD_W] >> w_rsh;

    always_comb begin
        unique case (r_op)
            OP_WRITE: w_val_top = (r_value << w_rsh) & w_mask_top;
            OP_SET:   w_val_top = w_mask_top;
            default:  w_val_top = '0;
        endcase
    end

    assign w_m128    = {w_mask_top, {WORD_W{1'b0}}} >> r_off;
    assign w_d128    = {w_val_top, {WORD_W{1'b0}}} >> r_off;
    assign w_new     = (w_pair & ~w_m128) | w_d128;
    assign w_elem_op = (r_op == OP_READ) || (r_op == OP_WRITE) || (r_op == OP_CLEAR)
                       || (r_op == OP_SET) || (r_op == OP_TEST);
    assign w_wr_op   = (r_op == OP_WRITE) || (r_op == OP_CLEAR) || (r_op == OP_SET);

    // ---------------- sweep byte enables ----------------
    logic [NBYTE_W-1:0] w_row_byte;
    logic [NBYTE_W-1:0] w_gap;
    logic               w_fill_act;

    assign w_row_byte = NBYTE_W'({r_row, 4'b0000});
    assign w_fill_act = (w_row_byte < r_nbytes);
    assign w_gap      = r_nbytes - w_row_byte;

    always_comb begin
        w_addr0 = w_word_nx[WORD_AW-1:1];
        w_addr1 = w_word[WORD_AW-1:1];
        w_we    = 1'b0;
        w_be0   = '1;
        w_be1   = '1;
        w_wd0   = '0;
        w_wd1   = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_addr0 = r_row[ROW_AW-1:0];
                w_addr1 = r_row[ROW_AW-1:0];
                w_we    = 1'b1;
            end
            S_FILL: begin
                w_addr0 = r_row[ROW_AW-1:0];
                w_addr1 = r_row[ROW_AW-1:0];
                w_we    = w_fill_act;
                w_wd0   = (r_op == OP_FILL1) ? '1 : '0;
                w_wd1   = (r_op == OP_FILL1) ? '1 : '0;
                // only bytes below the used length; bank 1 holds the upper 8 of a row
                for (int j = 0; j < LANES; j++) begin
                    w_be0[j] = (w_gap > NBYTE_W'(j));
                    w_be1[j] = (w_gap > NBYTE_W'(j + LANES));
                end
            end
            S_MOD: begin
                w_addr0 = w_rword_nx[WORD_AW-1:1];
                w_addr1 = r_word[WORD_AW-1:1];
                w_we    = r_ok && w_wr_op;
                w_wd0   = r_word[0] ? w_new[WORD_W-1:0] : w_new[2*WORD_W-1:WORD_W];
                w_wd1   = r_word[0] ? w_new[2*WORD_W-1:WORD_W] : w_new[WORD_W-1:0];
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    pbfa_bank u_bank0 (
        .i_clk   (i_clk),
        .i_addr  (w_addr0),
        .i_we    (w_we),
        .i_be    (w_be0),
        .i_wdata (w_wd0),
        .o_rdata (w_q0)
    );

    pbfa_bank u_bank1 (
        .i_clk   (i_clk),
        .i_addr  (w_addr1),
        .i_we    (w_we),
        .i_be    (w_be1),
        .i_wdata (w_wd1),
        .o_rdata (w_q1)
    );

    // ---------------- finish and output register ----------------
    logic              w_out_free;
    logic              w_fin;
    logic [WORD_W-1:0] w_fin_rd;
    logic              w_fin_nz;
    logic              w_fin_st;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fin      = (r_state == S_MOD) || ((r_state == S_FILL) && !w_fill_act);
    assign w_fin_rd   = ((r_state == S_MOD) && r_ok && (r_op == OP_READ)) ? w_elem : '0;
    assign w_fin_nz   = (r_state == S_MOD) && r_ok && (r_op == OP_TEST) && (w_elem != '0);
    assign w_fin_st   = (r_state == S_MOD) && w_elem_op && !r_ok;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_row[ROW_AW-1:0] == ROW_AW'(ROWS - 1)) n_state = S_IDLE;
            S_IDLE:  if (w_accept) n_state = w_is_fill ? S_DIV : S_MOD;
            S_MOD:   n_state = w_out_free ? S_IDLE : S_HOLD;
            S_DIV:   if (w_div_done) n_state = S_FILL;
            S_FILL:  if (!w_fill_act) n_state = w_out_free ? S_IDLE : S_HOLD;
            S_HOLD:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_CLEAR) || ((r_state == S_FILL) && w_fill_act)) begin
                r_row <= r_row + 1'b1;
            end else if (r_state == S_DIV) begin
                r_row <= '0;
            end
            if ((w_fin || (r_state == S_HOLD)) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV && w_div_done) begin
            r_nbytes <= NBYTE_W'((w_total + (BASE_W+1)'(7)) >> 3);
        end
        if (w_fin && w_out_free) begin
            r_out_rd <= w_fin_rd;
            r_out_nz <= w_fin_nz;
            r_out_st <= w_fin_st;
        end else if ((r_state == S_HOLD) && w_out_free) begin
            r_out_rd <= r_pend_rd;
            r_out_nz <= r_pend_nz;
            r_out_st <= r_pend_st;
        end
        if (w_fin && !w_out_free) begin
            r_pend_rd <= w_fin_rd;
            r_pend_nz <= w_fin_nz;
            r_pend_st <= w_fin_st;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_rd;
    assign o_is_nonzero = r_out_nz;
    assign o_status     = r_out_st;

endmodule

### rtl/pbfa_bank.sv
// One bank of the store: 64-bit words, byte write enables, registered read.
module pbfa_bank
    import pbfa_pkg::*;
(
    input  logic                 i_clk,
    input  logic [ROW_AW-1:0]    i_addr,
    input  logic                 i_we,
    input  logic [LANES-1:0]     i_be,
    input  logic [WORD_W-1:0]    i_wdata,
    output logic [WORD_W-1:0]    o_rdata
);

    logic [WORD_W-1:0] r_mem [ROWS];
    logic [WORD_W-1:0] r_rdata;

    // lane 0 is the most significant byte of the word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            for (int j = 0; j < LANES; j++) begin
                if (i_be[j]) begin
                    r_mem[i_addr][WORD_W-1-8*j -: 8] <= i_wdata[WORD_W-1-8*j -: 8];
                end
            end
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/pbfa_div.sv
// Restoring divider: capacity in bits over the element width, one bit a cycle.
module pbfa_div
    import pbfa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [UNIT_W-1:0]    i_divisor,
    output logic                 o_done,
    output logic [QUOT_W-1:0]    o_quot
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [QUOT_W-1:0] r_dvd;
    logic [QUOT_W-1:0] r_quot;
    logic [UNIT_W-1:0] r_rem;
    logic [UNIT_W-1:0] r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_run;
    logic              r_done;

    logic [UNIT_W:0]   w_trial;
    logic              w_fit;

    assign w_trial = {r_rem, r_dvd[QUOT_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(QUOT_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= QUOT_W'(CAP_BITS);
            r_quot <= '0;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_run) begin
            r_dvd  <= {r_dvd[QUOT_W-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], w_fit};
            r_rem  <= w_fit ? UNIT_W'(w_trial - {1'b0, r_div}) : w_trial[UNIT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### tb/pbfa_checker.sv
// Scoreboard for the packed bit-field array: mirrors the byte store and checks every result.
module pbfa_checker
    import pbfa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [2:0]         i_operation,
    input  logic [INDEX_W-1:0] i_index,
    input  logic [WORD_W-1:0]  i_value,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [WORD_W-1:0]  i_read_value,
    input  logic               i_is_nonzero,
    input  logic               i_status,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [COUNT_W-1:0] i_cfg_wdata,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);

    localparam int STORE_BYTES = CAP_BITS / 8;

    typedef struct packed {
        logic [WORD_W-1:0] read_value;
        logic              is_nonzero;
        logic              status;
    } t_result;

    logic [7:0]         mirror [STORE_BYTES];
    logic [UNIT_W-1:0]  unit_reg;
    logic [COUNT_W-1:0] count_reg;
    t_result            due_results [$];
    t_result            got_r;
    t_result            want_r;
    int                 fails;
    int                 checked;

    // width 0 behaves as 1, anything above 64 as 64
    function automatic int unsigned width_now();
        int unsigned w;
        w = unit_reg;
        if (w == 0) w = 1;
        if (w > MAX_UNIT) w = MAX_UNIT;
        return w;
    endfunction

    // count is clipped to what the store can hold at this width
    function automatic int unsigned count_now(input int unsigned w);
        int unsigned lim;
        lim = CAP_BITS / w;
        return (count_reg < lim) ? count_reg : lim;
    endfunction

    // MSB of the element sits at the lowest bit position; position p is bit 7-(p%8)
    function automatic logic [WORD_W-1:0] field_get(input int unsigned base,
                                                    input int unsigned w);
        logic [WORD_W-1:0] v;
        int unsigned       p;
        int unsigned       k;
        v = '0;
        for (k = 0; k < w; k++) begin
            p = base + k;
            v = {v[WORD_W-2:0], mirror[p >> 3][7 - (p & 7)]};
        end
        return v;
    endfunction

    function automatic void field_put(input int unsigned base, input int unsigned w,
                                      input logic [WORD_W-1:0] v);
        int unsigned p;
        int unsigned k;
        for (k = 0; k < w; k++) begin
            p = base + k;
            mirror[p >> 3][7 - (p & 7)] = v[w - 1 - k];
        end
    endfunction

    // applies one request to the mirror and returns the result it should produce
    function automatic t_result run_request(input logic [2:0] op,
                                            input logic [INDEX_W-1:0] idx,
                                            input logic [WORD_W-1:0] val);
        t_result           r;
        int unsigned       w;
        int unsigned       cnt;
        int unsigned       base;
        int unsigned       nbytes;
        int unsigned       b;
        logic [WORD_W-1:0] ones;
        r    = '0;
        w    = width_now();
        cnt  = count_now(w);
        ones = (w >= WORD_W) ? '1 : ((64'd1 << w) - 64'd1);
        case (op)
            OP_READ, OP_WRITE, OP_CLEAR, OP_SET, OP_TEST: begin
                if (idx >= cnt) begin
                    r.status = 1'b1;
                end else begin
                    base = idx * w;
                    case (op)
                        OP_READ:  r.read_value = field_get(base, w);
                        OP_WRITE: field_put(base, w, val & ones);
                        OP_CLEAR: field_put(base, w, '0);
                        OP_SET:   field_put(base, w, ones);
                        OP_TEST:  r.is_nonzero = (field_get(base, w) != '0);
                        default:  ;
                    endcase
                end
            end
            OP_FILL0, OP_FILL1: begin
                // whole bytes, slack bits of the last partial byte included
                nbytes = (cnt * w + 7) / 8;
                if (nbytes > STORE_BYTES) nbytes = STORE_BYTES;
                for (b = 0; b < nbytes; b++) begin
                    mirror[b] = (op == OP_FILL1) ? 8'hFF : 8'h00;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (mirror[b]) mirror[b] = 8'h00;
            unit_reg  = 7'd1;
            count_reg = 16'd32768;
            due_results.delete();
            fails     = 0;
            checked   = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_UNIT_BITS) unit_reg = i_cfg_wdata[UNIT_W-1:0];
                else count_reg = i_cfg_wdata;
            end
            if (i_in_valid && !i_in_stall) begin
                due_results.push_back(run_request(i_operation, i_index, i_value));
            end
            if (i_out_valid && !i_out_stall) begin
                got_r   = {i_read_value, i_is_nonzero, i_status};
                checked = checked + 1;
                if (due_results.size() == 0) begin
                    fails = fails + 1;
                    if (fails <= 10) begin
                        $display("ERROR: unexpected result read_value=%h is_nonzero=%0b status=%0b",
                                 got_r.read_value, got_r.is_nonzero, got_r.status);
                    end
                end else begin
                    want_r = due_results.pop_front();
                    if (got_r.read_value != want_r.read_value ||
                        got_r.is_nonzero != want_r.is_nonzero ||
                        got_r.status != want_r.status) begin
                        fails = fails + 1;
                        if (fails <= 10) begin
                            $display("ERROR: result %0d exp rv=%h nz=%0b st=%0b got rv=%h nz=%0b st=%0b",
                                     checked, want_r.read_value, want_r.is_nonzero,
                                     want_r.status, got_r.read_value, got_r.is_nonzero,
                                     got_r.status);
                        end
                    end
                end
            end
        end
        o_pending    <= due_results.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

### tb/tb.sv
// Testbench top for the packed bit-field array: clock, reset, stimulus and verdict.
module tb;
    import pbfa_pkg::*;

    localparam int LIMIT           = 1_000_000; // cycles before the run is declared hung
    localparam int HOLD_CYCLES     = 300;       // long output hold-off, fills the block up
    localparam int ITEMS_PER_PHASE = 75;
    localparam int NUM_PHASES      = 10;

    // op code 7 has no meaning; the block must answer it with an all-zero result
    localparam logic [2:0] OP_UNUSED = 3'd7;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} t_rx_mode;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    logic [2:0]         i_operation = OP_READ;
    logic [INDEX_W-1:0] i_index     = '0;
    logic [WORD_W-1:0]  i_value     = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [WORD_W-1:0]  o_read_value;
    logic               o_is_nonzero;
    logic               o_status;
    logic               i_cfg_we    = 1'b0;
    logic               i_cfg_index = CFG_UNIT_BITS;
    logic [COUNT_W-1:0] i_cfg_wdata = '0;

    int          fail_count;
    int          pending;
    int          checked;
    int unsigned cycles     = 0;
    int unsigned cur_count  = 32768; // usable elements under the current settings
    int unsigned last_idx   = 0;     // last element written, biases later index picks
    int          n_sent     = 0;
    int          n_fill     = 0;
    int          n_reject   = 0;
    int          burst_left = 0;
    bit          hold_req   = 1'b0;

    // width/count settings for the random phases: reset values, widest, width 0,
    // width above 64, odd widths, counts past capacity, count 0 and count 1
    int unsigned phase_unit  [NUM_PHASES] = '{1, 64, 0, 127, 13, 7, 33, 5, 63, 9};
    int unsigned phase_count [NUM_PHASES] = '{32768, 512, 100, 600, 37, 65535, 0, 1,
                                              520, 3641};

    always #5 i_clk = ~i_clk;

    packed_bitfield_array_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_index      (i_index),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_value (o_read_value),
        .o_is_nonzero (o_is_nonzero),
        .o_status     (o_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    pbfa_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_index      (i_index),
        .i_value      (i_value),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_read_value (o_read_value),
        .i_is_nonzero (o_is_nonzero),
        .i_status     (o_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // watchdog: covers the post-reset clearing pass and every fill at worst-case stalls
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Run hung after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: stall pattern changes between segments of random length. Once asked,
    // it holds off for a long stretch so the block backs up into its input.
    initial begin : receiver
        int       seg;
        t_rx_mode mode;
        bit       held;
        held = 1'b0;
        forever begin
            seg  = $urandom_range(20, 200);
            mode = t_rx_mode'($urandom_range(0, 3));
            repeat (seg) begin
                @(posedge i_clk);
                if (hold_req && !held) begin
                    held = 1'b1;
                    i_out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end else begin
                    case (mode)
                        RX_OPEN:  i_out_stall <= 1'b0;
                        RX_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                        RX_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                        default:  i_out_stall <= ~i_out_stall;
                    endcase
                end
            end
        end
    end

    // Present one transaction and hold it until accepted, then decide whether
    // the current burst ends. Valid is only dropped when a gap follows.
    task automatic offer(input logic [2:0] op, input int unsigned idx,
                         input logic [WORD_W-1:0] val);
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_index     <= idx[INDEX_W-1:0];
        i_value     <= val;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
        if (op == OP_FILL0 || op == OP_FILL1) n_fill++;
        else if (op != OP_UNUSED && idx >= cur_count) n_reject++;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    // Stop sending and wait for every outstanding result. The first edge lets
    // the checker's count catch up with a transaction accepted just now.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Both registers are written on back-to-back edges; only called when idle.
    task automatic set_config(input int unsigned unit_val, input int unsigned count_val);
        int unsigned w;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_UNIT_BITS;
        i_cfg_wdata <= unit_val[COUNT_W-1:0];
        @(posedge i_clk);
        i_cfg_index <= CFG_ELEM_CNT;
        i_cfg_wdata <= count_val[COUNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        w = unit_val[UNIT_W-1:0];
        if (w == 0) w = 1;
        if (w > MAX_UNIT) w = MAX_UNIT;
        cur_count = (count_val[COUNT_W-1:0] < CAP_BITS / w) ? count_val[COUNT_W-1:0]
                                                            : CAP_BITS / w;
    endtask

    // Mostly in-range indexes, biased toward the last written element and its
    // neighbors (straddled bytes), plus both ends, just past the end, and noise.
    function automatic int unsigned pick_index();
        int unsigned r;
        int unsigned j;
        r = $urandom_range(0, 99);
        if (cur_count == 0 || r >= 90) return $urandom_range(0, 32767);
        if (r >= 80) begin
            j = cur_count + $urandom_range(0, 2);
            return (j > 32767) ? 32767 : j;
        end
        if (r >= 70) return (r & 1) ? 0 : cur_count - 1;
        if (r >= 35 && last_idx < cur_count) begin
            j = last_idx + $urandom_range(0, 2);
            j = (j == 0) ? 0 : j - 1;
            return (j >= cur_count) ? cur_count - 1 : j;
        end
        return $urandom_range(0, cur_count - 1);
    endfunction

    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    initial begin : stimulus
        int unsigned idx;
        int unsigned r;
        logic [2:0]  op;
        int          k;
        int          p;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings (1-bit elements, full store), both index
        // extremes, fills over the whole store, the unused op code
        offer(OP_READ, 0, '0);
        offer(OP_WRITE, 32767, '1);
        offer(OP_READ, 32767, '0);
        offer(OP_TEST, 32767, '0);
        offer(OP_FILL1, 0, '0);
        offer(OP_READ, 12345, '0);
        offer(OP_FILL0, 32767, '1);
        offer(OP_TEST, 12345, '0);
        offer(OP_UNUSED, 32767, '1);

        // directed: 64-bit elements, bit order, last element and one past it
        settle();
        set_config(64, 512);
        offer(OP_WRITE, 511, '1);
        offer(OP_READ, 511, '0);
        offer(OP_WRITE, 0, 64'h8000_0000_0000_0001);
        offer(OP_READ, 0, '0);
        offer(OP_READ, 512, '0);
        offer(OP_WRITE, 512, '1);
        offer(OP_CLEAR, 511, '0);
        offer(OP_TEST, 511, '0);
        offer(OP_SET, 1, '0);
        offer(OP_TEST, 1, '0);
        offer(OP_READ, 1, '0);

        // directed: odd width, value wider than the element, fill with slack bits
        settle();
        set_config(13, 37);
        offer(OP_WRITE, 36, '1);
        offer(OP_READ, 36, '0);
        offer(OP_FILL1, 0, '0);

        // random phases, one per setting; writes are often read back at once
        for (p = 0; p < NUM_PHASES; p++) begin
            settle();
            set_config(phase_unit[p], phase_count[p]);
            if (p == 4) hold_req = 1'b1;
            k = 0;
            while (k < ITEMS_PER_PHASE) begin
                r   = $urandom_range(0, 99);
                idx = pick_index();
                if (r < 30)      op = OP_WRITE;
                else if (r < 52) op = OP_READ;
                else if (r < 64) op = OP_TEST;
                else if (r < 72) op = OP_CLEAR;
                else if (r < 80) op = OP_SET;
                else if (r < 83) op = OP_FILL0;
                else if (r < 86) op = OP_FILL1;
                else if (r < 88) op = OP_UNUSED;
                else             op = OP_READ;
                offer(op, idx, pick_value());
                k++;
                if (op == OP_WRITE && idx < cur_count) begin
                    last_idx = idx;
                    if ($urandom_range(0, 1) == 1) begin
                        offer(OP_READ, idx, pick_value());
                        k++;
                    end
                end
                // now and then drain completely mid-phase
                if ($urandom_range(0, 59) == 0) settle();
            end
        end

        settle();
        repeat (20) @(posedge i_clk);

        $display("Covered %0d requests (%0d fills, %0d out-of-range) over %0d settings.",
                 n_sent, n_fill, n_reject, NUM_PHASES + 2);
        $display("Scored %0d results, %0d failures, %0d outstanding.",
                 checked, fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
